// ===== rtl/core/skse_pkg.sv =====
// ----------------------------------------------------------------------------
// skse_pkg
// shared types and constants of the sorted key search engine
// ----------------------------------------------------------------------------
package skse_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 10;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_BIN   = 2'd1,
        KIND_EXP   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RD_MID   = 2'd0,
        RD_ZERO  = 2'd1,
        RD_BOUND = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    mem_wr;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    win_narrow;
        logic    bound_double;
        logic    exp_win;
        logic    res_found;
        logic    res_miss;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic win_empty;
        logic key_eq;
        logic key_gt;
        logic bound_lt_count;
        logic count_zero;
    } t_status;

endpackage

// ===== rtl/core/skse_ctrl.sv =====
// ----------------------------------------------------------------------------
// skse_ctrl
// search sequencer: table writes and probe order for binary and exponential search
// ----------------------------------------------------------------------------
module skse_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  skse_pkg::t_kind    i_kind,
    output logic               o_s_tready,
    input  logic               i_m_tready,
    output logic               o_m_tvalid,
    input  skse_pkg::t_status  i_status,
    output skse_pkg::t_cmd     o_cmd
);
    import skse_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_B_RD,
        ST_B_CMP,
        ST_E0_RD,
        ST_E0_CMP,
        ST_E_RD,
        ST_E_CMP,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   w_accept;
    t_cmd   w_cmd;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_kind)
                        KIND_WRITE: begin
                            w_cmd.mem_wr = 1'b1;
                        end
                        KIND_BIN: begin
                            w_cmd.load = 1'b1;
                            n_state    = ST_B_RD;
                        end
                        KIND_EXP: begin
                            w_cmd.load = 1'b1;
                            if (i_status.count_zero) begin
                                w_cmd.res_miss = 1'b1;
                                n_state        = ST_FIN;
                            end else begin
                                n_state = ST_E0_RD;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_B_RD: begin
                if (i_status.win_empty) begin
                    w_cmd.res_miss = 1'b1;
                    n_state        = ST_FIN;
                end else begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_MID;
                    n_state      = ST_B_CMP;
                end
            end
            ST_B_CMP: begin
                if (i_status.key_eq) begin
                    w_cmd.res_found = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    w_cmd.win_narrow = 1'b1;
                    n_state          = ST_B_RD;
                end
            end
            ST_E0_RD: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RD_ZERO;
                n_state      = ST_E0_CMP;
            end
            ST_E0_CMP: begin
                if (i_status.key_eq) begin
                    w_cmd.res_found = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    n_state = ST_E_RD;
                end
            end
            ST_E_RD: begin
                if (i_status.bound_lt_count) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = RD_BOUND;
                    n_state      = ST_E_CMP;
                end else begin
                    w_cmd.exp_win = 1'b1;
                    n_state       = ST_B_RD;
                end
            end
            ST_E_CMP: begin
                if (!i_status.key_gt) begin
                    w_cmd.bound_double = 1'b1;
                    n_state            = ST_E_RD;
                end else begin
                    w_cmd.exp_win = 1'b1;
                    n_state       = ST_B_RD;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/skse_dp.sv =====
// ----------------------------------------------------------------------------
// skse_dp
// key table, search window, bound and result registers
// ----------------------------------------------------------------------------
module skse_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [skse_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [skse_pkg::SLOT_W-1:0]   i_slot,
    input  logic [skse_pkg::KEY_W-1:0]    i_key,
    input  skse_pkg::t_cmd                i_cmd,
    output skse_pkg::t_status             o_status,
    output logic                          o_found,
    output logic [skse_pkg::POS_W-1:0]    o_pos
);
    import skse_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = CW + 2;

    logic [KEY_W-1:0]     r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]     r_rdata;
    logic [KEY_W-1:0]     r_key;
    logic [CNT_W-1:0]     r_entries;
    logic signed [WW-1:0] r_lo, r_hi;
    logic [WW-1:0]        r_bound;
    logic [WW-1:0]        r_probe;
    logic                 r_found;
    logic [WW-1:0]        r_pos;
    logic                 r_o_found;
    logic [POS_W-1:0]     r_o_pos;

    logic [31:0]          w_cnt32;
    logic signed [WW-1:0] w_count;
    logic signed [WW-1:0] w_cnt_m1;
    logic [WW-1:0]        w_sum;
    logic [WW-1:0]        w_mid;
    logic [WW-1:0]        w_rd_idx;
    logic [31:0]          w_slot32;
    logic [31:0]          w_pos32;
    logic signed [WW-1:0] w_bound_s;

    // cover count clipped to the table depth
    assign w_cnt32  = ({21'd0, r_entries} > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                             : {21'd0, r_entries};
    assign w_count  = w_cnt32[WW-1:0];
    assign w_cnt_m1 = w_count - WW'(1);
    assign w_sum    = r_lo + r_hi;
    assign w_mid    = w_sum >> 1;
    assign w_slot32 = {22'd0, i_slot};
    assign w_bound_s = r_bound;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_MID:   w_rd_idx = w_mid;
            RD_ZERO:  w_rd_idx = '0;
            RD_BOUND: w_rd_idx = r_bound;
            default:  w_rd_idx = '0;
        endcase
    end

    assign o_status.win_empty      = (r_lo > r_hi);
    assign o_status.key_eq         = (r_rdata == r_key);
    assign o_status.key_gt         = ($signed(r_rdata) > $signed(r_key));
    assign o_status.bound_lt_count = (w_bound_s < w_count);
    assign o_status.count_zero     = (r_entries == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && (w_slot32 < 32'(TABLE_DEPTH))) begin
            r_mem[w_slot32[AW-1:0]] <= i_key;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_idx[AW-1:0]];
            r_probe <= w_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= '0;
        end else if (i_cfg_we) begin
            r_entries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= i_key;
            r_lo    <= '0;
            r_hi    <= w_cnt_m1;
            r_bound <= WW'(1);
        end
        if (i_cmd.win_narrow) begin
            if (o_status.key_gt) begin
                r_hi <= r_probe - WW'(1);
            end else begin
                r_lo <= r_probe + WW'(1);
            end
        end
        if (i_cmd.bound_double) begin
            r_bound <= r_bound << 1;
        end
        if (i_cmd.exp_win) begin
            r_lo <= r_bound >> 1;
            r_hi <= (w_bound_s < w_cnt_m1) ? w_bound_s : w_cnt_m1;
        end
        if (i_cmd.res_found) begin
            r_found <= 1'b1;
            r_pos   <= r_probe;
        end
        if (i_cmd.res_miss) begin
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.out_load) begin
            r_o_found <= r_found;
            r_o_pos   <= w_pos32[POS_W-1:0];
        end
    end

    assign w_pos32 = 32'(r_pos);
    assign o_found = r_o_found;
    assign o_pos   = r_o_pos;

endmodule

// ===== rtl/core/sorted_key_search_engine_top.sv =====
// sequence: a write is taken while idle; binary search reads then compares for each probe and
// ends on a hit or an empty window; exponential search probes entry 0 first, then doubles the
// bound, then runs binary search in the narrowed window; with no entries in use it misses unprobed
// throughput: one item at a time; a write every cycle while idle, a search holds the input until
// its result is loaded, and longer while the previous result waits for m_tready
// reset: synchronous active low, clears count and handshake state; key table is not cleared
// ----------------------------------------------------------------------------
// sorted_key_search_engine_top
// binary and exponential search over a table of signed keys
// ----------------------------------------------------------------------------
module sorted_key_search_engine_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // slot_index[9:0], key[41:10], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[9:0], zero pad
    output logic        m_tuser    // found
);
    import skse_pkg::*;

    t_cmd             w_cmd;
    t_status          w_status;
    logic             w_found;
    logic [POS_W-1:0] w_pos;

    skse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_kind     (t_kind'(s_tuser)),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    skse_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_slot      (s_tdata[9:0]),
        .i_key       (s_tdata[41:10]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_found     (w_found),
        .o_pos       (w_pos)
    );

    assign m_tdata = {6'd0, w_pos};
    assign m_tuser = w_found;

endmodule
